// ===== sv/mafl_pkg.sv =====
// ----------------------------------------------------------------------------
// mafl_pkg
// Shared types, codes and helpers for the meter address filter.
// ----------------------------------------------------------------------------
package mafl_pkg;

  localparam int TableEntriesDef = 16;
  localparam int CfgW            = 5;
  localparam int PrefixW         = 4;

  localparam logic [15:0]        ANY_MFCT     = 16'hffff;
  localparam logic [7:0]         ANY_BYTE     = 8'hff;
  localparam logic [PrefixW-1:0] PREFIX_EXACT = 4'd8;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_ADDR = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [3:0]  slot;
    logic [31:0] id_value;
    logic [3:0]  prefix_digits;
    logic [15:0] mfct_value;
    logic [7:0]  version_value;
    logic [7:0]  type_value;
    logic        negative_rule;
    logic        required_rule;
    logic        last_address;
  } in_word_t;

  typedef struct packed {
    logic telegram_match;
    logic by_wildcard;
    logic rejected;
  } out_word_t;

  typedef struct packed {
    logic [31:0]        id_value;
    logic [PrefixW-1:0] prefix;
    logic [15:0]        mfct;
    logic [7:0]         version;
    logic [7:0]         dev_type;
    logic               negative;
    logic               required;
  } rule_t;

  typedef struct packed {
    logic        last;
    logic [31:0] id_value;
    logic [15:0] mfct;
    logic [7:0]  version;
    logic [7:0]  dev_type;
    logic        negative;
    logic        plain;
    logic        exact;
    logic        req_seen;
    logic        req_met;
  } probe_t;

  function automatic logic id_match(input logic [31:0] rule_id,
                                    input logic [PrefixW-1:0] prefix,
                                    input logic [31:0] addr_id);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (prefix > PrefixW'(i)) begin
        if (rule_id[31-4*i -: 4] != addr_id[31-4*i -: 4]) ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

// ===== sv/mafl_cell.sv =====
// ----------------------------------------------------------------------------
// mafl_cell
// One rule slot: holds a rule and checks the passing address word against it.
// ----------------------------------------------------------------------------
module mafl_cell #(
  parameter int CellIndex = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  logic [3:0]                slot_i,
  input  mafl_pkg::rule_t           rule_i,
  input  logic [mafl_pkg::CfgW-1:0] count_i,
  input  logic                      valid_i,
  input  mafl_pkg::probe_t          probe_i,
  output logic                      valid_o,
  output mafl_pkg::probe_t          probe_o
);
  import mafl_pkg::*;

  rule_t  rule_q;
  probe_t probe_d, probe_q;
  logic   valid_q;
  logic   active, hit;

  always_ff @(posedge clk_i) begin
    if (load_i && (int'(slot_i) == CellIndex)) begin
      rule_q <= rule_i;
    end
  end

  assign active = (int'(count_i) > CellIndex);
  assign hit = ((rule_q.mfct == ANY_MFCT) || (rule_q.mfct == probe_i.mfct)) &&
               ((rule_q.version == ANY_BYTE) || (rule_q.version == probe_i.version)) &&
               ((rule_q.dev_type == ANY_BYTE) || (rule_q.dev_type == probe_i.dev_type)) &&
               id_match(rule_q.id_value, rule_q.prefix, probe_i.id_value);

  always_comb begin
    probe_d = probe_i;
    if (active) begin
      if (rule_q.required) probe_d.req_seen = 1'b1;
      if (hit) begin
        priority if (rule_q.negative) begin
          probe_d.negative = 1'b1;
        end else if (rule_q.required) begin
          probe_d.req_met = 1'b1;
        end else begin
          probe_d.plain = 1'b1;
          if (rule_q.prefix == PREFIX_EXACT) probe_d.exact = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    probe_q <= probe_d;
  end

  assign valid_o = valid_q;
  assign probe_o = probe_q;

endmodule

// ===== sv/meter_address_filter.sv =====
// ----------------------------------------------------------------------------
// meter_address_filter
// Checks radio meter telegram addresses against a table of address rules.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a word is taken at a clock edge with start high and busy
//   low. A load word writes one rule and leaves busy low.
//   An address word enters a row of TableEntries rule cells (16 by default),
//   one cell per cycle, and busy stays high until it leaves the last cell; the
//   next word may be given in the cycle busy drops.
//   On an address word marked last, the result word shows on result_o with
//   result_strobe_o high for one cycle, in the cycle busy drops.
//   Other words give no result. The receiver cannot stall results.
//   Config channel: cfg_data_i sets the number of checked entries; it is
//   always ready, and the user must write it only while the block is idle;
//   the block itself has no check for this. Reset clears the entry count,
//   the per-telegram flags and busy; rules hold no value until loaded.
// ----------------------------------------------------------------------------
module meter_address_filter #(
  parameter int TableEntries = mafl_pkg::TableEntriesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  mafl_pkg::in_word_t        item_i,
  output mafl_pkg::out_word_t       result_o,
  output logic                      result_strobe_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [mafl_pkg::CfgW-1:0] cfg_data_i
);
  import mafl_pkg::*;

  logic            accept, load_fire, addr_fire;
  rule_t           new_rule;
  probe_t          inject;
  logic            chain_valid [TableEntries+1];
  probe_t          chain_probe [TableEntries+1];
  logic            exit_valid;
  probe_t          exit_probe;

  logic [CfgW-1:0] count_q;
  logic            busy_q;
  logic            match_q, neg_q, req_seen_q, req_met_q, wild_q;
  logic            match_d, neg_d, req_seen_d, req_met_d, wild_d;
  out_word_t       result_d, result_q;
  logic            strobe_q;

  assign accept    = start && !busy_q;
  assign load_fire = accept && (item_i.opcode == OP_LOAD);
  assign addr_fire = accept && (item_i.opcode == OP_ADDR);

  assign cfg_ready_o = 1'b1;

  always_comb begin
    new_rule.id_value = item_i.id_value;
    new_rule.prefix   = (item_i.prefix_digits > PREFIX_EXACT) ? PREFIX_EXACT
                                                              : item_i.prefix_digits;
    new_rule.mfct     = item_i.mfct_value;
    new_rule.version  = item_i.version_value;
    new_rule.dev_type = item_i.type_value;
    new_rule.negative = item_i.negative_rule;
    new_rule.required = item_i.required_rule;
  end

  always_comb begin
    inject.last     = item_i.last_address;
    inject.id_value = item_i.id_value;
    inject.mfct     = item_i.mfct_value;
    inject.version  = item_i.version_value;
    inject.dev_type = item_i.type_value;
    inject.negative = 1'b0;
    inject.plain    = 1'b0;
    inject.exact    = 1'b0;
    inject.req_seen = 1'b0;
    inject.req_met  = 1'b0;
  end

  assign chain_valid[0] = addr_fire;
  assign chain_probe[0] = inject;

  for (genvar k = 0; k < TableEntries; k++) begin : g_cell
    mafl_cell #(
      .CellIndex(k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .load_i (load_fire),
      .slot_i (item_i.slot),
      .rule_i (new_rule),
      .count_i(count_q),
      .valid_i(chain_valid[k]),
      .probe_i(chain_probe[k]),
      .valid_o(chain_valid[k+1]),
      .probe_o(chain_probe[k+1])
    );
  end

  assign exit_valid = chain_valid[TableEntries];
  assign exit_probe = chain_probe[TableEntries];

  always_comb begin
    match_d    = match_q;
    neg_d      = neg_q;
    req_seen_d = req_seen_q | exit_probe.req_seen;
    req_met_d  = req_met_q | exit_probe.req_met;
    wild_d     = wild_q;
    priority if (exit_probe.negative) begin
      neg_d = 1'b1;
    end else if (exit_probe.plain) begin
      match_d = 1'b1;
      wild_d  = !exit_probe.exact;
    end
    result_d.telegram_match = match_d && !neg_d && !(req_seen_d && !req_met_d);
    result_d.by_wildcard    = result_d.telegram_match && wild_d;
    result_d.rejected       = neg_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      busy_q     <= 1'b0;
      match_q    <= 1'b0;
      neg_q      <= 1'b0;
      req_seen_q <= 1'b0;
      req_met_q  <= 1'b0;
      wild_q     <= 1'b0;
      strobe_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) count_q <= cfg_data_i;
      if (addr_fire) begin
        busy_q <= 1'b1;
      end else if (exit_valid) begin
        busy_q <= 1'b0;
      end
      strobe_q <= exit_valid && exit_probe.last;
      if (exit_valid) begin
        if (exit_probe.last) begin
          match_q    <= 1'b0;
          neg_q      <= 1'b0;
          req_seen_q <= 1'b0;
          req_met_q  <= 1'b0;
          wild_q     <= 1'b0;
        end else begin
          match_q    <= match_d;
          neg_q      <= neg_d;
          req_seen_q <= req_seen_d;
          req_met_q  <= req_met_d;
          wild_q     <= wild_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exit_valid && exit_probe.last) result_q <= result_d;
  end

  assign busy            = busy_q;
  assign result_o        = result_q;
  assign result_strobe_o = strobe_q;

endmodule

// ===== sv/mafl_checker.sv =====
// ----------------------------------------------------------------------------
// mafl_checker
// Port-level checks for the meter address filter, bound to the top level.
// ----------------------------------------------------------------------------
module mafl_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input mafl_pkg::in_word_t  item_i,
  input mafl_pkg::out_word_t result_o,
  input logic                result_strobe_o
);
  import mafl_pkg::*;

  a_addr_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (item_i.opcode == OP_ADDR)) |=> busy)
    else $error("address word did not raise busy");

  a_strobe_at_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $fell(busy))
    else $error("result shown without a finished scan");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |=> !result_strobe_o)
    else $error("result strobe longer than one cycle");

  a_wild_needs_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> (result_o.telegram_match || !result_o.by_wildcard))
    else $error("wildcard flag without a match");

  a_match_not_filtered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> !(result_o.telegram_match && result_o.rejected))
    else $error("match reported on a filtered telegram");

endmodule

bind meter_address_filter mafl_checker u_mafl_checker (.*);

// ===== test/meter_address_filter_tb.sv =====
// ----------------------------------------------------------------------------
// meter_address_filter_tb
// Loads address rules and sends telegram addresses to the filter. Expected
// results come from a scoreboard that keeps its own copy of the rule table,
// the entry count and the per-telegram flags. Every result word is checked
// field by field against the oldest pending expectation. The run walks
// through several table sizes and sender idle rates.
// ----------------------------------------------------------------------------
module meter_address_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mafl_pkg::*;

  localparam int Latency    = TableEntriesDef + 2;
  localparam int StallLimit = 1000;

  class filter_scoreboard;
    rule_t           rules [TableEntriesDef];
    logic [CfgW-1:0] entries;
    bit              match_seen, neg_hit, req_seen, req_met, wild;
    out_word_t       expected_q [$];
    int              errors, results, passes, filtered, wildcards;

    function new();
      entries    = '0;
      match_seen = 0;
      neg_hit    = 0;
      req_seen   = 0;
      req_met    = 0;
      wild       = 0;
      errors     = 0;
      results    = 0;
      passes     = 0;
      filtered   = 0;
      wildcards  = 0;
    endfunction

    static function logic [31:0] digit_mask(logic [PrefixW-1:0] prefix);
      if (prefix >= PREFIX_EXACT) return '1;
      return ~(32'hffff_ffff >> (4 * prefix));
    endfunction

    function void set_entries(logic [CfgW-1:0] v);
      entries = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_word(in_word_t w);
      rule_t     r;
      int        span;
      bit        plain, exact, negative, hit;
      out_word_t res;
      if (w.opcode == OP_LOAD) begin
        r.id_value = w.id_value;
        r.prefix   = (w.prefix_digits > PREFIX_EXACT) ? PREFIX_EXACT : w.prefix_digits;
        r.mfct     = w.mfct_value;
        r.version  = w.version_value;
        r.dev_type = w.type_value;
        r.negative = w.negative_rule;
        r.required = w.required_rule;
        rules[w.slot] = r;
        return;
      end
      span     = (entries > TableEntriesDef) ? TableEntriesDef : int'(entries);
      plain    = 0;
      exact    = 0;
      negative = 0;
      for (int k = 0; k < span; k++) begin
        r = rules[k];
        if (r.required) req_seen = 1;
        hit = (r.mfct == ANY_MFCT || r.mfct == w.mfct_value) &&
              (r.version == ANY_BYTE || r.version == w.version_value) &&
              (r.dev_type == ANY_BYTE || r.dev_type == w.type_value) &&
              (((r.id_value ^ w.id_value) & digit_mask(r.prefix)) == '0);
        if (hit) begin
          if (r.negative) negative = 1;
          else if (r.required) req_met = 1;
          else begin
            plain = 1;
            if (r.prefix >= PREFIX_EXACT) exact = 1;
          end
        end
      end
      if (negative) neg_hit = 1;
      else if (plain) begin
        match_seen = 1;
        wild       = !exact;
      end
      if (!w.last_address) return;
      res.telegram_match = match_seen && !neg_hit && !(req_seen && !req_met);
      res.by_wildcard    = res.telegram_match && wild;
      res.rejected       = neg_hit;
      expected_q = {expected_q, res};
      match_seen = 0;
      neg_hit    = 0;
      req_seen   = 0;
      req_met    = 0;
      wild       = 0;
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $error("result word %b with no telegram pending", got);
        return;
      end
      want = expected_q.pop_front();
      results++;
      passes    += want.telegram_match;
      wildcards += want.by_wildcard;
      filtered  += want.rejected;
      if (got.telegram_match !== want.telegram_match) begin
        errors++;
        $error("telegram_match: expected %0b, got %0b", want.telegram_match,
               got.telegram_match);
      end
      if (got.by_wildcard !== want.by_wildcard) begin
        errors++;
        $error("by_wildcard: expected %0b, got %0b", want.by_wildcard,
               got.by_wildcard);
      end
      if (got.rejected !== want.rejected) begin
        errors++;
        $error("rejected: expected %0b, got %0b", want.rejected,
               got.rejected);
      end
    endfunction
  endclass

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            start       = 1'b0;
  logic            busy;
  in_word_t        item_i      = '0;
  out_word_t       result_o;
  logic            result_strobe_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [CfgW-1:0] cfg_data_i  = '0;

  filter_scoreboard sb;
  int idle_pct    = 0;
  int words_sent  = 0;
  int settings    = 0;
  int idle_cycles = 0;

  meter_address_filter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .item_i          (item_i),
    .result_o        (result_o),
    .result_strobe_o (result_strobe_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) sb.check_result(result_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_strobe_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_word_t random_word();
    in_word_t w;
    w.opcode        = 1'($urandom_range(0, 1));
    w.slot          = 4'($urandom_range(0, 15));
    w.id_value      = $urandom();
    w.prefix_digits = 4'($urandom_range(0, 15));
    w.mfct_value    = 16'($urandom_range(0, 16'hffff));
    w.version_value = 8'($urandom_range(0, 8'hff));
    w.type_value    = 8'($urandom_range(0, 8'hff));
    w.negative_rule = 1'($urandom_range(0, 1));
    w.required_rule = 1'($urandom_range(0, 1));
    w.last_address  = 1'($urandom_range(0, 1));
    return w;
  endfunction

  function automatic in_word_t rule_word(logic [3:0] slot, logic [31:0] id,
                                         logic [3:0] pre, logic [15:0] mf,
                                         logic [7:0] vr, logic [7:0] ty,
                                         bit neg, bit req);
    in_word_t w;
    w               = random_word();
    w.opcode        = OP_LOAD;
    w.slot          = slot;
    w.id_value      = id;
    w.prefix_digits = pre;
    w.mfct_value    = mf;
    w.version_value = vr;
    w.type_value    = ty;
    w.negative_rule = neg;
    w.required_rule = req;
    return w;
  endfunction

  function automatic in_word_t addr_word(logic [31:0] id, logic [15:0] mf,
                                         logic [7:0] vr, logic [7:0] ty, bit last);
    in_word_t w;
    w               = random_word();
    w.opcode        = OP_ADDR;
    w.id_value      = id;
    w.mfct_value    = mf;
    w.version_value = vr;
    w.type_value    = ty;
    w.last_address  = last;
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    int gap;
    gap = 0;
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= w;
    do @(posedge clk_i); while (busy);
    sb.note_word(w);
    words_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    do @(posedge clk_i); while (busy);
    repeat (Latency) @(posedge clk_i);
  endtask

  task automatic write_entries(input logic [CfgW-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_entries(v);
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  task automatic run_phase(input logic [CfgW-1:0] count, input int pct, input int n);
    rule_t       r;
    logic [31:0] m, id;
    logic [15:0] mf;
    logic [7:0]  vr, ty;
    int          base, nadr, pick;
    bit          paused;
    drain_results();
    write_entries(count);
    idle_pct = pct;
    base     = words_sent;
    paused   = 0;
    while (words_sent - base < n) begin
      if (!paused && words_sent - base >= n / 2) begin
        drain_results();
        paused = 1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        send_word(rule_word(4'($urandom_range(0, 15)), $urandom(),
                            ($urandom_range(0, 1) != 0) ? PREFIX_EXACT :
                                                          4'($urandom_range(0, 15)),
                            ($urandom_range(0, 3) == 0) ? ANY_MFCT :
                                                          16'($urandom_range(0, 16'hffff)),
                            ($urandom_range(0, 3) == 0) ? ANY_BYTE : 8'($urandom_range(0, 255)),
                            ($urandom_range(0, 3) == 0) ? ANY_BYTE : 8'($urandom_range(0, 255)),
                            $urandom_range(0, 9) == 0, $urandom_range(0, 15) == 0));
      end else if (pick < 28) begin
        send_word(random_word());
      end else begin
        nadr = $urandom_range(1, 4);
        for (int i = 0; i < nadr; i++) begin
          if ($urandom_range(0, 9) < 7) begin
            r  = sb.rules[$urandom_range(0, TableEntriesDef - 1)];
            m  = filter_scoreboard::digit_mask(r.prefix);
            id = (r.id_value & m) | ($urandom() & ~m);
            mf = (r.mfct == ANY_MFCT) ? 16'($urandom_range(0, 16'hffff)) : r.mfct;
            vr = (r.version == ANY_BYTE) ? 8'($urandom_range(0, 255)) : r.version;
            ty = (r.dev_type == ANY_BYTE) ? 8'($urandom_range(0, 255)) : r.dev_type;
            if ($urandom_range(0, 7) == 0) id = id ^ (32'h1 << $urandom_range(0, 31));
          end else begin
            id = $urandom();
            mf = 16'($urandom_range(0, 16'hffff));
            vr = 8'($urandom_range(0, 255));
            ty = 8'($urandom_range(0, 255));
          end
          send_word(addr_word(id, mf, vr, ty, i == nadr - 1));
        end
      end
    end
  endtask

  initial begin
    logic [CfgW-1:0] counts [7];
    int              pcts   [7];
    sb     = new();
    counts = '{5'd16, 5'd31, 5'd1, 5'd9, 5'd0, 5'd5, 5'd16};
    pcts   = '{0, 74, 0, 23, 74, 23, 0};
    counts[5] = 5'($urandom_range(2, 15));
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table: nothing can match
    send_word(addr_word(32'h0, 16'h0, 8'h0, 8'h0, 1));
    send_word(rule_word(4'd0, 32'h1234_5678, PREFIX_EXACT, ANY_MFCT, ANY_BYTE, ANY_BYTE, 0, 0));
    send_word(rule_word(4'd1, 32'hABCD_0000, 4'd4, 16'h1234, ANY_BYTE, ANY_BYTE, 0, 0));
    send_word(rule_word(4'd2, 32'h0, 4'd0, 16'hBEEF, 8'h01, 8'h07, 0, 0));
    send_word(rule_word(4'd3, 32'hDEAD_0000, 4'd4, ANY_MFCT, ANY_BYTE, ANY_BYTE, 1, 0));
    send_word(rule_word(4'd4, 32'hCAFE_0000, 4'd4, ANY_MFCT, ANY_BYTE, ANY_BYTE, 0, 1));
    send_word(rule_word(4'd5, 32'hFFFF_FFFF, 4'd15, ANY_MFCT, ANY_BYTE, ANY_BYTE, 0, 0));
    send_word(rule_word(4'd6, 32'h0F0F_0F0F, PREFIX_EXACT, 16'h0001, 8'h02, 8'h03, 1, 1));
    for (int k = 7; k < TableEntriesDef; k++) begin
      send_word(rule_word(4'(k), 32'h0, 4'(k - 7), 16'h0, 8'h0, 8'h0, 0, 0));
    end
    drain_results();
    write_entries(5'(TableEntriesDef));
    send_word(addr_word(32'h1234_5678, 16'h0, 8'h0, 8'h0, 0));
    send_word(addr_word(32'hCAFE_1111, 16'h0, 8'h0, 8'h0, 1));
    send_word(addr_word(32'hABCD_9999, 16'h1234, 8'h55, 8'hAA, 0));
    send_word(addr_word(32'hCAFE_0000, ANY_MFCT, ANY_BYTE, ANY_BYTE, 1));
    send_word(addr_word(32'hDEAD_1234, 16'h1234, 8'h0, 8'h0, 0));
    send_word(addr_word(32'hCAFE_FFFF, 16'h0, 8'h0, 8'h0, 1));
    send_word(addr_word(32'hFFFF_FFFF, ANY_MFCT, ANY_BYTE, ANY_BYTE, 0));
    send_word(addr_word(32'h1111_1111, 16'hBEEF, 8'h01, 8'h07, 0));
    send_word(addr_word(32'hCAFE_0001, 16'h0, 8'h0, 8'h0, 1));
    send_word(addr_word(32'h0F0F_0F0F, 16'h0001, 8'h02, 8'h03, 1));

    for (int p = 0; p < 7; p++) run_phase(counts[p], pcts[p], 75);
    drain_results();

    $display("Sent %0d words over %0d table-size settings, checked %0d telegram results.",
             words_sent, settings, sb.results);
    $display("Of those, %0d passed (%0d by wildcard) and %0d were filtered out.",
             sb.passes, sb.wildcards, sb.filtered);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/mafl_pkg.sv
sv/mafl_cell.sv
sv/meter_address_filter.sv
sv/mafl_checker.sv
test/meter_address_filter_tb.sv
